// File: design/lgs_pkg.sv
// Shared types and constants for the life grid generation step block.
`default_nettype none

package lgs_pkg;

   // Grid geometry
   localparam int GRID_ROWS = 48;
   localparam int GRID_COLS = 64;

   // Field and register widths
   localparam int ROW_W      = 64;
   localparam int IDX_W      = 6;
   localparam int ROWS_CFG_W = 6;
   localparam int COLS_CFG_W = 7;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   // Row address into the grid store, and a row counter that can hold the row count
   localparam int ROW_AW = $clog2(GRID_ROWS);
   localparam int CNT_W  = $clog2(GRID_ROWS + 1);

   // Register reset values
   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 6'd48;
   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd64;

   // Rule B3/S23 neighbour counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Mask of the physically present columns
   localparam logic [ROW_W:0] WIDE_ONE = {{ROW_W{1'b0}}, 1'b1};
   localparam logic [ROW_W:0] COL_FULL_WIDE = (WIDE_ONE << GRID_COLS) - WIDE_ONE;
   localparam logic [ROW_W-1:0] COL_FULL_MASK = COL_FULL_WIDE[ROW_W-1:0];

   // Register indexes
   typedef enum logic [0:0] {
      REG_ROWS_IN_USE = 1'b0,
      REG_COLS_IN_USE = 1'b1
   } reg_index_type;

   // Command codes
   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_STEP  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_STEP_HERE,
      ST_STEP_ROW,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// File: design/lgs_req_if.sv
// Command channel interface of the life grid block.
`default_nettype none

interface lgs_req_if
   import lgs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   func_type          func;
   logic [IDX_W-1:0]  row_index;
   logic [ROW_W-1:0]  row_bits;

   modport source (output valid, output func, output row_index, output row_bits,
                   input ready);
   modport sink   (input valid, input func, input row_index, input row_bits,
                   output ready);
endinterface

`default_nettype wire

// File: design/lgs_rsp_if.sv
// Result channel interface of the life grid block.
`default_nettype none

interface lgs_rsp_if
   import lgs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  row_bits_out;
   logic              index_ok;

   modport source (output valid, output row_bits_out, output index_ok, input ready);
   modport sink   (input valid, input row_bits_out, input index_ok, output ready);
endinterface

`default_nettype wire

// File: design/lgs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module lgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 48
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/life_grid_generation_step.sv
// Top level of the life grid generation step block (rule B3/S23).
//
//   channel   direction  handshake         payload
//   req_chan  in         valid/ready       func, row_index, row_bits
//   rsp_chan  out        valid/ready       row_bits_out, index_ok
//   csr_*     in/out     APB, pready = 1   rows_in_use @0x0, cols_in_use @0x4
//
// Write, clear and rejected commands go from ST_IDLE to ST_RESP; a read passes ST_READ_WAIT first.
// A step loads row 0 in ST_STEP_HERE, then sweeps in ST_STEP_ROW: the single row update unit
// processes one row per cycle, fed by the grid RAM read port one row ahead.
// Synchronous reset clears all rows at once through per-row valid bits; clear does the same.
// One command is in flight at a time; req_chan.ready is low until its result is registered,
// and a result held by a stalled rsp_chan.ready holds the next result back.
`default_nettype none

module life_grid_generation_step
   import lgs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   lgs_req_if.sink                req_chan,
   lgs_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   // Sequencer and configuration
   state_type               state_ff, state_in;
   logic [ROWS_CFG_W-1:0]   rows_ff;
   logic [COLS_CFG_W-1:0]   cols_ff;

   // Row window and counter of the sweep
   logic [ROW_W-1:0]        above_ff, above_in;
   logic [ROW_W-1:0]        here_ff, here_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   // Per-row valid bits of the grid store
   logic [GRID_ROWS-1:0]    valid_ff, valid_in;
   logic                    rd_valid_ff, rd_valid_in;

   // Pending and delivered result
   logic [ROW_W-1:0]        res_bits_ff, res_bits_in;
   logic                    res_ok_ff, res_ok_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]        rsp_bits_ff, rsp_bits_in;
   logic                    rsp_ok_ff, rsp_ok_in;

   // RAM ports
   logic                    wr_en;
   logic [ROW_AW-1:0]       wr_addr;
   logic [ROW_W-1:0]        wr_data;
   logic                    rd_en;
   logic [ROW_AW-1:0]       rd_addr;
   logic [ROW_W-1:0]        rd_data;

   // Derived values
   logic                    req_fire;
   logic                    slot_free;
   logic                    csr_write;
   logic [CNT_W-1:0]        rows_act;
   logic [COLS_CFG_W-1:0]   cols_act;
   logic [ROW_W:0]          col_wide;
   logic [ROW_W-1:0]        col_mask;
   logic                    idx_ok;
   logic [ROW_AW-1:0]       idx_addr;
   logic [ROW_AW-1:0]       cnt_addr;
   logic                    last_row;
   logic [ROW_W-1:0]        rd_masked;
   logic [ROW_W-1:0]        below;

   // One generation of one row: count the eight neighbours of each column
   function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] above,
                                                 input logic [ROW_W-1:0] here,
                                                 input logic [ROW_W-1:0] below_row);
      logic [ROW_W+1:0] a_pad;
      logic [ROW_W+1:0] h_pad;
      logic [ROW_W+1:0] b_pad;
      logic [3:0]       n;
      logic [ROW_W-1:0] res;
      a_pad = {1'b0, above, 1'b0};
      h_pad = {1'b0, here, 1'b0};
      b_pad = {1'b0, below_row, 1'b0};
      res   = '0;
      for (int c = 0; c < ROW_W; c++) begin
         n = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
           + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2])
           + 4'(h_pad[c]) + 4'(h_pad[c+2]);
         res[c] = (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && here[c]);
      end
      return res;
   endfunction

   // Grid store
   lgs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (GRID_ROWS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshakes
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.row_bits_out = rsp_bits_ff;
   assign rsp_chan.index_ok     = rsp_ok_ff;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      unique case (reg_index_type'(csr_paddr[2]))
         REG_ROWS_IN_USE: csr_prdata = CSR_DW'(rows_ff);
         REG_COLS_IN_USE: csr_prdata = CSR_DW'(cols_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Clamp the registers to the grid and build the column mask
   assign rows_act = (int'(rows_ff) < GRID_ROWS) ? CNT_W'(rows_ff) : CNT_W'(GRID_ROWS);
   assign cols_act = (int'(cols_ff) < GRID_COLS) ? cols_ff : COLS_CFG_W'(GRID_COLS);
   assign col_wide = (WIDE_ONE << cols_act) - WIDE_ONE;
   assign col_mask = col_wide[ROW_W-1:0];

   // Addressing
   assign idx_ok    = int'(req_chan.row_index) < int'(rows_act);
   assign idx_addr  = ROW_AW'(req_chan.row_index);
   assign cnt_addr  = cnt_ff[ROW_AW-1:0];
   assign last_row  = (int'(cnt_ff) + 1) >= int'(rows_act);
   assign rd_masked = rd_valid_ff ? (rd_data & col_mask) : '0;
   assign below     = last_row ? '0 : rd_masked;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.func == FUNC_READ && idx_ok) begin
                  state_in = ST_READ_WAIT;
               end else if (req_chan.func == FUNC_STEP) begin
                  state_in = ST_STEP_HERE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_READ_WAIT: state_in = ST_RESP;
         ST_STEP_HERE: state_in = (rows_act == '0) ? ST_RESP : ST_STEP_ROW;
         ST_STEP_ROW:  state_in = last_row ? ST_RESP : ST_STEP_ROW;
         ST_RESP:      state_in = slot_free ? ST_IDLE : ST_RESP;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM control
   always_comb begin
      above_in     = above_ff;
      here_in      = here_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      res_bits_in  = res_bits_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_ok_in    = rsp_ok_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_addr;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      // drop a delivered result
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_bits_in = '0;
               res_ok_in   = 1'b1;
               unique case (req_chan.func)
                  FUNC_WRITE: begin
                     res_ok_in = idx_ok;
                     if (idx_ok) begin
                        wr_en              = 1'b1;
                        wr_addr            = idx_addr;
                        wr_data            = req_chan.row_bits & COL_FULL_MASK;
                        valid_in[idx_addr] = 1'b1;
                     end
                  end
                  FUNC_READ: begin
                     res_ok_in = idx_ok;
                     if (idx_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = idx_addr;
                     end
                  end
                  FUNC_STEP: begin
                     // fetch row 0 ahead of the sweep
                     rd_en   = (rows_act != '0);
                     rd_addr = '0;
                  end
                  FUNC_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                     res_ok_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            res_bits_in = rd_masked;
         end
         ST_STEP_HERE: begin
            // load the window with row 0 and fetch row 1
            here_in  = rd_masked;
            above_in = '0;
            cnt_in   = '0;
            if (int'(rows_act) > 1) begin
               rd_en   = 1'b1;
               rd_addr = ROW_AW'(1);
            end
         end
         ST_STEP_ROW: begin
            // update one row, slide the window, fetch two rows ahead
            wr_en              = 1'b1;
            wr_addr            = cnt_addr;
            wr_data            = next_row(above_ff, here_ff, below) & col_mask;
            valid_in[cnt_addr] = 1'b1;
            above_in           = here_ff;
            here_in            = below;
            cnt_in             = cnt_ff + CNT_W'(1);
            if ((int'(cnt_ff) + 2) < int'(rows_act)) begin
               rd_en   = 1'b1;
               rd_addr = ROW_AW'(int'(cnt_ff) + 2);
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = res_bits_ff;
               rsp_ok_in    = res_ok_ff;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (reg_index_type'(csr_paddr[2]))
               REG_ROWS_IN_USE: rows_ff <= csr_pwdata[ROWS_CFG_W-1:0];
               REG_COLS_IN_USE: cols_ff <= csr_pwdata[COLS_CFG_W-1:0];
               default: begin
                  rows_ff <= rows_ff;
               end
            endcase
         end
      end
      above_ff    <= above_in;
      here_ff     <= here_in;
      cnt_ff      <= cnt_in;
      rd_valid_ff <= rd_valid_in;
      res_bits_ff <= res_bits_in;
      res_ok_ff   <= res_ok_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

endmodule

`default_nettype wire

// File: design/lgs_checker.sv
// Port-level assertions for the life grid block, bound to its top level.
`default_nettype none

module lgs_checker
   import lgs_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic [1:0]       req_func,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [ROW_W-1:0] rsp_row_bits_out,
   input wire logic             rsp_index_ok
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_bits_out)
                                  && $stable(rsp_index_ok))
      else $error("stalled result changed or dropped");

   // One command at a time: busy right after a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while previous one in flight");

   // A step cannot finish in the next cycle
   a_step_not_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_STEP) |=> !$rose(rsp_valid))
      else $error("step result appeared too early");

   // A rejected command carries no cells
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_index_ok |-> rsp_row_bits_out == '0)
      else $error("rejected command returned cell data");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_func         (req_chan.func),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_row_bits_out (rsp_chan.row_bits_out),
   .rsp_index_ok     (rsp_chan.index_ok)
);

`default_nettype wire
